// ===== rtl/core/tarhp_pkg.sv =====
// Shared types, constants and the octal field scanner of the tar header parser.
// Depends on nothing; every other file but tarhp_queue refers to it by scoped names.
package tarhp_pkg;

  localparam int HDR_IDX_W = 9;
  localparam int BSUM_W    = 17;
  localparam int SIZE_W    = 33;
  localparam int SUM_W     = 21;
  localparam int SKIP_W    = 34;

  localparam logic [HDR_IDX_W-1:0] HDR_LAST   = 9'd511;
  localparam logic [HDR_IDX_W-1:0] SIZE_FIRST = 9'd124;
  localparam logic [HDR_IDX_W-1:0] SIZE_LAST  = 9'd135;
  localparam logic [HDR_IDX_W-1:0] SUM_FIRST  = 9'd148;
  localparam logic [HDR_IDX_W-1:0] SUM_LAST   = 9'd155;
  localparam logic [HDR_IDX_W-1:0] TYPE_IDX   = 9'd156;

  localparam logic [BSUM_W-1:0] BSUM_INIT = 17'd256;
  localparam logic [SIZE_W-1:0] SIZE_MAX  = {SIZE_W{1'b1}};
  localparam logic [SIZE_W-1:0] SUM_MAX   = {{(SIZE_W-SUM_W){1'b0}}, {SUM_W{1'b1}}};
  localparam logic [SKIP_W-1:0] BLOCK_RND = 34'd511;

  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_SEVEN = 8'h37;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_SKIP,
    PH_DONE
  } phase_t;

  typedef enum logic [1:0] {
    SCAN_LEADING,
    SCAN_DIGITS,
    SCAN_STOPPED
  } scan_t;

  typedef struct packed {
    scan_t             st;
    logic [SIZE_W-1:0] acc;
  } scan_res_t;

  // Result fields that do not depend on the offset width.
  typedef struct packed {
    logic [7:0]        entry_type;
    logic [SIZE_W-1:0] data_length;
    logic              bad_checksum;
    logic              end_of_archive;
  } res_fields_t;

  // One character of an octal field. The caller flags when another digit would
  // overflow the field's range, in which case the value saturates at maxv.
  function automatic scan_res_t octal_scan(logic [7:0] b, scan_t st,
                                           logic [SIZE_W-1:0] acc, logic ovf,
                                           logic [SIZE_W-1:0] maxv);
    scan_res_t r;
    logic      octal;
    octal = (b >= CHAR_ZERO) && (b <= CHAR_SEVEN);
    r.st  = st;
    r.acc = acc;
    case (st)
      SCAN_LEADING: begin
        if (b != CHAR_SPACE) begin
          if (octal) begin
            r.acc = {{(SIZE_W-3){1'b0}}, b[2:0]};
            r.st  = SCAN_DIGITS;
          end else begin
            r.st = SCAN_STOPPED;
          end
        end
      end
      SCAN_DIGITS: begin
        if (!octal) begin
          r.st = SCAN_STOPPED;
        end else if (ovf) begin
          r.acc = maxv;
        end else begin
          r.acc = {acc[SIZE_W-4:0], b[2:0]};
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/core/tarhp_front.sv =====
// Front end of the tar header parser: takes archive bytes, runs the header
// checks and the data skip, and pushes one record per header. Uses tarhp_pkg.
module tarhp_front #(
  parameter int OFFSET_BITS = 40
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     archive_valid,
  input  logic [7:0]               archive_byte,
  output logic                     archive_stall,
  output logic                     q_push,
  output tarhp_pkg::res_fields_t   q_fields,
  output logic [OFFSET_BITS-1:0]   q_offset,
  input  logic                     q_full
);

  tarhp_pkg::phase_t                      phase, phase_next;
  logic [tarhp_pkg::HDR_IDX_W-1:0]        hdr_idx, hdr_idx_next;
  logic [tarhp_pkg::BSUM_W-1:0]           byte_sum, byte_sum_next;
  logic [tarhp_pkg::SIZE_W-1:0]           size_acc, size_acc_next;
  tarhp_pkg::scan_t                       size_st, size_st_next;
  logic [tarhp_pkg::SUM_W-1:0]            sum_acc, sum_acc_next;
  tarhp_pkg::scan_t                       sum_st, sum_st_next;
  logic                                   sum_zero, sum_zero_next;
  logic [7:0]                             type_byte, type_byte_next;
  logic [tarhp_pkg::SKIP_W-1:0]           skip_cnt, skip_cnt_next;
  logic [OFFSET_BITS-1:0]                 byte_off, byte_off_next;

  logic                                   fire;
  logic [OFFSET_BITS-1:0]                 off_inc;
  logic [tarhp_pkg::SKIP_W-1:0]           skip_dec;
  logic [tarhp_pkg::SKIP_W-1:0]           skip_new;
  logic [tarhp_pkg::BSUM_W-1:0]           sum_upd;
  tarhp_pkg::scan_res_t                   size_r;
  tarhp_pkg::scan_res_t                   sum_r;

  // Only the last header byte needs room in the queue.
  assign archive_stall = (phase == tarhp_pkg::PH_HEADER) &&
                         (hdr_idx == tarhp_pkg::HDR_LAST) && q_full;
  assign fire     = archive_valid && !archive_stall;
  assign off_inc  = byte_off + {{(OFFSET_BITS-1){1'b0}}, 1'b1};
  assign skip_dec = (skip_cnt != '0) ? skip_cnt - {{(tarhp_pkg::SKIP_W-1){1'b0}}, 1'b1}
                                     : '0;
  assign skip_new = ({1'b0, size_acc} + tarhp_pkg::BLOCK_RND) & ~tarhp_pkg::BLOCK_RND;
  assign sum_upd  = byte_sum + {{(tarhp_pkg::BSUM_W-8){1'b0}}, archive_byte};

  assign size_r = tarhp_pkg::octal_scan(archive_byte, size_st, size_acc,
                                        |size_acc[tarhp_pkg::SIZE_W-1:tarhp_pkg::SIZE_W-3],
                                        tarhp_pkg::SIZE_MAX);
  assign sum_r  = tarhp_pkg::octal_scan(archive_byte, sum_st,
                                        {{(tarhp_pkg::SIZE_W-tarhp_pkg::SUM_W){1'b0}}, sum_acc},
                                        |sum_acc[tarhp_pkg::SUM_W-1:tarhp_pkg::SUM_W-3],
                                        tarhp_pkg::SUM_MAX);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= tarhp_pkg::PH_HEADER;
      hdr_idx   <= '0;
      byte_sum  <= tarhp_pkg::BSUM_INIT;
      size_acc  <= '0;
      size_st   <= tarhp_pkg::SCAN_LEADING;
      sum_acc   <= '0;
      sum_st    <= tarhp_pkg::SCAN_LEADING;
      sum_zero  <= 1'b0;
      type_byte <= '0;
      skip_cnt  <= '0;
      byte_off  <= '0;
    end else begin
      phase     <= phase_next;
      hdr_idx   <= hdr_idx_next;
      byte_sum  <= byte_sum_next;
      size_acc  <= size_acc_next;
      size_st   <= size_st_next;
      sum_acc   <= sum_acc_next;
      sum_st    <= sum_st_next;
      sum_zero  <= sum_zero_next;
      type_byte <= type_byte_next;
      skip_cnt  <= skip_cnt_next;
      byte_off  <= byte_off_next;
    end
  end

  always_comb begin
    phase_next     = phase;
    hdr_idx_next   = hdr_idx;
    byte_sum_next  = byte_sum;
    size_acc_next  = size_acc;
    size_st_next   = size_st;
    sum_acc_next   = sum_acc;
    sum_st_next    = sum_st;
    sum_zero_next  = sum_zero;
    type_byte_next = type_byte;
    skip_cnt_next  = skip_cnt;
    byte_off_next  = byte_off;
    q_push         = 1'b0;
    q_fields       = '0;
    q_offset       = '0;
    if (fire) begin
      case (phase)
        tarhp_pkg::PH_SKIP: begin
          byte_off_next = off_inc;
          skip_cnt_next = skip_dec;
          if (skip_dec == '0) begin
            phase_next = tarhp_pkg::PH_HEADER;
          end
        end
        tarhp_pkg::PH_HEADER: begin
          byte_off_next = off_inc;
          if ((hdr_idx < tarhp_pkg::SUM_FIRST) || (hdr_idx > tarhp_pkg::SUM_LAST)) begin
            byte_sum_next = sum_upd;
          end
          if (hdr_idx == tarhp_pkg::TYPE_IDX) begin
            type_byte_next = archive_byte;
          end
          if ((hdr_idx >= tarhp_pkg::SIZE_FIRST) && (hdr_idx <= tarhp_pkg::SIZE_LAST)) begin
            size_acc_next = size_r.acc;
            size_st_next  = size_r.st;
          end
          if ((hdr_idx >= tarhp_pkg::SUM_FIRST) && (hdr_idx <= tarhp_pkg::SUM_LAST)) begin
            if (hdr_idx == tarhp_pkg::SUM_FIRST) begin
              sum_zero_next = (archive_byte == 8'h00);
            end
            sum_acc_next = sum_r.acc[tarhp_pkg::SUM_W-1:0];
            sum_st_next  = sum_r.st;
          end
          if (hdr_idx != tarhp_pkg::HDR_LAST) begin
            hdr_idx_next = hdr_idx + {{(tarhp_pkg::HDR_IDX_W-1){1'b0}}, 1'b1};
          end else begin
            q_push = 1'b1;
            if (sum_zero) begin
              q_fields.end_of_archive = 1'b1;
              phase_next              = tarhp_pkg::PH_DONE;
            end else begin
              q_fields.entry_type   = type_byte;
              q_fields.data_length  = size_acc;
              q_fields.bad_checksum = ({{(tarhp_pkg::SUM_W-tarhp_pkg::BSUM_W){1'b0}},
                                        sum_upd} != sum_acc);
              q_offset              = off_inc;
              skip_cnt_next         = skip_new;
              phase_next            = (skip_new == '0) ? tarhp_pkg::PH_HEADER
                                                       : tarhp_pkg::PH_SKIP;
            end
            hdr_idx_next   = '0;
            byte_sum_next  = tarhp_pkg::BSUM_INIT;
            size_acc_next  = '0;
            size_st_next   = tarhp_pkg::SCAN_LEADING;
            sum_acc_next   = '0;
            sum_st_next    = tarhp_pkg::SCAN_LEADING;
            sum_zero_next  = 1'b0;
            type_byte_next = '0;
          end
        end
        default: begin
          // After the end marker every byte is taken and dropped.
        end
      endcase
    end
  end

endmodule

// ===== rtl/core/tarhp_queue.sv =====
// Two-entry record queue between the parser front end and the output stage.
// Generic in its data width; no package dependency.
module tarhp_queue #(
  parameter int WIDTH = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  logic [WIDTH-1:0] mem [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign dout  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/core/tarhp_back.sv =====
// Output stage of the tar header parser: moves records from the queue into the
// result register and holds them while the receiver stalls. Uses tarhp_pkg.
module tarhp_back #(
  parameter int OFFSET_BITS = 40
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           q_empty,
  input  tarhp_pkg::res_fields_t         q_fields,
  input  logic [OFFSET_BITS-1:0]         q_offset,
  output logic                           q_pop,
  output logic                           result_valid,
  input  logic                           result_stall,
  output logic [7:0]                     entry_type,
  output logic [tarhp_pkg::SIZE_W-1:0]   data_length,
  output logic [OFFSET_BITS-1:0]         data_offset,
  output logic                           bad_checksum,
  output logic                           end_of_archive
);

  assign q_pop = !q_empty && (!result_valid || !result_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (!result_valid || !result_stall) begin
      result_valid <= !q_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      entry_type     <= q_fields.entry_type;
      data_length    <= q_fields.data_length;
      data_offset    <= q_offset;
      bad_checksum   <= q_fields.bad_checksum;
      end_of_archive <= q_fields.end_of_archive;
    end
  end

endmodule

// ===== rtl/core/tar_header_stream_parser_unit.sv =====
// Top level of the tar header parser: front end, record queue, output stage.
// Depends on tarhp_pkg, tarhp_front, tarhp_queue and tarhp_back.
//
//   channel   ports                                    direction  transaction
//   archive   archive_valid, archive_stall,            in         one archive byte
//             archive_byte
//   result    result_valid, result_stall, entry_type,  out        one header record
//             data_length, data_offset, bad_checksum,
//             end_of_archive
//
// The unit takes one archive byte per cycle while archive_stall is low; all per-byte
// work (checksum add, octal shift-add, skip count, offset count) is combinational
// logic of the front end. A record enters the queue at the edge that takes the last
// header byte and then moves into the result register, later if earlier records wait.
// Reset (rst, synchronous) puts the parser at the start of a header at offset 0.
// Only the last byte of a header can be stalled, and only while the two-entry
// queue is full; result_stall never holds up data or header bytes otherwise.
module tar_header_stream_parser_unit #(
  parameter int OFFSET_BITS = 40
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           archive_valid,
  output logic                           archive_stall,
  input  logic [7:0]                     archive_byte,
  output logic                           result_valid,
  input  logic                           result_stall,
  output logic [7:0]                     entry_type,
  output logic [tarhp_pkg::SIZE_W-1:0]   data_length,
  output logic [OFFSET_BITS-1:0]         data_offset,
  output logic                           bad_checksum,
  output logic                           end_of_archive
);

  localparam int FIELDS_W = $bits(tarhp_pkg::res_fields_t);
  localparam int REC_W    = FIELDS_W + OFFSET_BITS;

  logic                        q_push;
  logic                        q_pop;
  logic                        q_full;
  logic                        q_empty;
  tarhp_pkg::res_fields_t      push_fields;
  logic [OFFSET_BITS-1:0]      push_offset;
  logic [REC_W-1:0]            q_dout;
  tarhp_pkg::res_fields_t      pop_fields;
  logic [OFFSET_BITS-1:0]      pop_offset;

  // The front end classifies each byte as header, data or trailing and builds
  // the record on the last header byte.
  tarhp_front #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .archive_valid (archive_valid),
    .archive_byte  (archive_byte),
    .archive_stall (archive_stall),
    .q_push        (q_push),
    .q_fields      (push_fields),
    .q_offset      (push_offset),
    .q_full        (q_full)
  );

  // The queue lets the front end keep taking bytes while a record waits.
  tarhp_queue #(
    .WIDTH (REC_W)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   ({push_fields, push_offset}),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_dout),
    .empty (q_empty)
  );

  assign pop_fields = q_dout[REC_W-1:OFFSET_BITS];
  assign pop_offset = q_dout[OFFSET_BITS-1:0];

  tarhp_back #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .q_empty        (q_empty),
    .q_fields       (pop_fields),
    .q_offset       (pop_offset),
    .q_pop          (q_pop),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .entry_type     (entry_type),
    .data_length    (data_length),
    .data_offset    (data_offset),
    .bad_checksum   (bad_checksum),
    .end_of_archive (end_of_archive)
  );

  // The front end must never push a record into a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("record pushed into a full queue");

  // An end marker carries no entry information.
  a_end_marker_clean: assert property (@(posedge clk) disable iff (rst)
    (result_valid && end_of_archive) |->
      (entry_type == '0) && (data_length == '0) && (data_offset == '0) && !bad_checksum)
    else $error("end marker with nonzero fields");

  // A waiting record reaches an empty output register in the next cycle.
  a_back_loads: assert property (@(posedge clk) disable iff (rst)
    (!q_empty && !result_valid) |=> result_valid)
    else $error("output stage failed to load a waiting record");

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for tar_header_stream_parser_unit: streams tar archives
// byte by byte and checks every header record against its own parser model.
// Depends on tarhp_pkg (port widths, phase and scan enums) and the unit itself.
module testbench;

  localparam int OFFS_W      = 40;
  localparam int CYCLE_LIMIT = 5_000_000;

  // Header layout as the stimulus builder and the parser model see it.
  localparam int HDR_BYTES = 512;
  localparam int SIZE_AT   = 124;
  localparam int SIZE_LEN  = 12;
  localparam int CSUM_AT   = 148;
  localparam int CSUM_LEN  = 8;
  localparam int TYPE_AT   = 156;

  localparam logic [7:0] ASCII_NUL   = 8'h00;
  localparam logic [7:0] ASCII_SPACE = 8'h20;
  localparam logic [7:0] ASCII_ZERO  = 8'h30;
  localparam logic [7:0] ASCII_SEVEN = 8'h37;

  localparam logic [63:0] LENGTH_CAP = 64'h1_FFFF_FFFF;  // 2^33 - 1
  localparam logic [63:0] CSUM_CAP   = 64'h1F_FFFF;      // 2^21 - 1

  // One header record as it leaves the result channel.
  typedef struct {
    logic [7:0]                   etype;
    logic [tarhp_pkg::SIZE_W-1:0] len;
    logic [OFFS_W-1:0]            offs;
    logic                         bad;
    logic                         eoa;
  } hdr_rec_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                         archive_valid = 1'b0;
  logic                         archive_stall;
  logic [7:0]                   archive_byte  = 8'h00;
  logic                         result_valid;
  logic                         result_stall  = 1'b0;
  logic [7:0]                   entry_type;
  logic [tarhp_pkg::SIZE_W-1:0] data_length;
  logic [OFFS_W-1:0]            data_offset;
  logic                         bad_checksum;
  logic                         end_of_archive;

  tar_header_stream_parser_unit #(
    .OFFSET_BITS(OFFS_W)
  ) DUT (
    .clk           (clk),
    .rst           (rst),
    .archive_valid (archive_valid),
    .archive_stall (archive_stall),
    .archive_byte  (archive_byte),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .entry_type    (entry_type),
    .data_length   (data_length),
    .data_offset   (data_offset),
    .bad_checksum  (bad_checksum),
    .end_of_archive(end_of_archive)
  );

  always #4 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Parser model. It advances once per accepted archive byte and queues the
  // record that the unit must produce when a header completes.
  // ---------------------------------------------------------------------------
  tarhp_pkg::phase_t model_ph;
  logic [8:0]        model_hidx;
  logic [16:0]       model_bsum;
  logic [63:0]       model_size_val;
  tarhp_pkg::scan_t  model_size_st;
  logic [63:0]       model_csum_val;
  tarhp_pkg::scan_t  model_csum_st;
  logic              model_csum_nul;
  logic [7:0]        model_type;
  logic [33:0]       model_skip;
  logic [OFFS_W-1:0] model_offs;

  hdr_rec_t pending_recs[$];

  // Counters for the checks and the closing summary.
  int mismatches     = 0;
  int records_seen   = 0;
  int bad_seen       = 0;
  int bytes_sent     = 0;
  int headers_sent   = 0;
  int burst_left     = 0;
  int cycle_cnt      = 0;
  int stall_tick     = 0;
  int stall_mode     = 0;
  int finale_kind    = 0;

  logic [7:0] hdr_buf [0:HDR_BYTES-1];

  // Leading spaces are skipped, the first non-octal character ends the field,
  // and a value that would leave the field's range sticks at its cap.
  function automatic void scan_char(input logic [7:0] c, inout tarhp_pkg::scan_t st,
                                    inout logic [63:0] acc, input logic [63:0] cap);
    logic        is_oct;
    logic [63:0] nxt;
    is_oct = (c >= ASCII_ZERO) && (c <= ASCII_SEVEN);
    nxt    = {acc[60:0], c[2:0]};
    case (st)
      tarhp_pkg::SCAN_LEADING: begin
        if (c != ASCII_SPACE) begin
          if (is_oct) begin
            acc = {61'd0, c[2:0]};
            st  = tarhp_pkg::SCAN_DIGITS;
          end else begin
            st = tarhp_pkg::SCAN_STOPPED;
          end
        end
      end
      tarhp_pkg::SCAN_DIGITS: begin
        if (!is_oct) begin
          st = tarhp_pkg::SCAN_STOPPED;
        end else begin
          acc = (nxt > cap) ? cap : nxt;
        end
      end
      default: begin
      end
    endcase
  endfunction

  function automatic void clear_hdr_state();
    model_hidx     = '0;
    model_bsum     = 17'd256;
    model_size_val = '0;
    model_size_st  = tarhp_pkg::SCAN_LEADING;
    model_csum_val = '0;
    model_csum_st  = tarhp_pkg::SCAN_LEADING;
    model_csum_nul = 1'b0;
    model_type     = '0;
  endfunction

  function automatic void model_reset();
    model_ph   = tarhp_pkg::PH_HEADER;
    clear_hdr_state();
    model_skip = '0;
    model_offs = '0;
  endfunction

  function automatic void model_byte(input logic [7:0] c);
    hdr_rec_t rec;
    int       idx;
    if (model_ph == tarhp_pkg::PH_DONE) return;
    model_offs = model_offs + 1'b1;
    if (model_ph == tarhp_pkg::PH_SKIP) begin
      if (model_skip != 0) model_skip = model_skip - 1'b1;
      if (model_skip == 0) model_ph = tarhp_pkg::PH_HEADER;
      return;
    end
    idx = int'(model_hidx);
    // The checksum field itself is summed as if it held spaces (the 256 seed).
    if (idx < CSUM_AT || idx >= CSUM_AT + CSUM_LEN) model_bsum = model_bsum + c;
    if (idx == TYPE_AT) model_type = c;
    if (idx >= SIZE_AT && idx < SIZE_AT + SIZE_LEN)
      scan_char(c, model_size_st, model_size_val, LENGTH_CAP);
    if (idx >= CSUM_AT && idx < CSUM_AT + CSUM_LEN) begin
      if (idx == CSUM_AT) model_csum_nul = (c == ASCII_NUL);
      scan_char(c, model_csum_st, model_csum_val, CSUM_CAP);
    end
    if (idx != HDR_BYTES - 1) begin
      model_hidx = model_hidx + 1'b1;
      return;
    end
    if (model_csum_nul) begin
      // End of archive: a bare marker, and the parser goes deaf until reset.
      rec.etype = '0;
      rec.len   = '0;
      rec.offs  = '0;
      rec.bad   = 1'b0;
      rec.eoa   = 1'b1;
      pending_recs.push_back(rec);
      clear_hdr_state();
      model_ph = tarhp_pkg::PH_DONE;
      return;
    end
    rec.etype = model_type;
    rec.len   = model_size_val[tarhp_pkg::SIZE_W-1:0];
    rec.offs  = model_offs;
    rec.bad   = (model_csum_val != {47'd0, model_bsum});
    rec.eoa   = 1'b0;
    pending_recs.push_back(rec);
    // Data occupies whole 512-byte blocks; an empty entry skips nothing.
    model_skip = ({1'b0, model_size_val[tarhp_pkg::SIZE_W-1:0]} + 34'd511) & ~34'd511;
    model_ph   = (model_skip == 0) ? tarhp_pkg::PH_HEADER : tarhp_pkg::PH_SKIP;
    clear_hdr_state();
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking: every record taken from the unit is matched, field by
  // field, against the oldest queued expectation.
  // ---------------------------------------------------------------------------
  hdr_rec_t want;

  function automatic void cmp_field(input string fname, input logic [63:0] exp_v,
                                    input logic [63:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h",
               $time, fname, exp_v, act_v);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (pending_recs.size() == 0) begin
        $display("%0t: unexpected record: expected none, actual type 0x%0h length %0d",
                 $time, entry_type, data_length);
        mismatches++;
      end else begin
        want = pending_recs.pop_front();
        cmp_field("entry_type", 64'(want.etype), 64'(entry_type));
        cmp_field("data_length", 64'(want.len), 64'(data_length));
        cmp_field("data_offset", 64'(want.offs), 64'(data_offset));
        cmp_field("bad_checksum", 64'(want.bad), 64'(bad_checksum));
        cmp_field("end_of_archive", 64'(want.eoa), 64'(end_of_archive));
        records_seen++;
        if (bad_checksum === 1'b1) bad_seen++;
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d records still expected",
               $time, cycle_cnt, pending_recs.size());
      $display("** tar_header_stream_parser_unit: FAILED **");
      $finish;
    end
  end

  // The result side stalls in randomly picked modes: none, light random,
  // heavy random, and a fixed periodic pattern.
  always @(negedge clk) begin
    if (stall_tick % 200 == 0) stall_mode = $urandom_range(0, 3);
    stall_tick++;
    case (stall_mode)
      0:       result_stall <= 1'b0;
      1:       result_stall <= ($urandom_range(0, 9) < 3);
      2:       result_stall <= ($urandom_range(0, 9) < 8);
      default: result_stall <= ((stall_tick % 32) < 24);
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sending side. The sender runs in bursts with random gaps in between; about
  // a quarter of the bursts follow the previous one without any gap.
  // ---------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] c);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      burst_left = $urandom_range(8, 600);
      if (gap != 0) begin
        archive_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    archive_valid <= 1'b1;
    archive_byte  <= c;
    burst_left--;
    @(posedge clk);
    while (archive_stall) @(posedge clk);
    model_byte(c);
    bytes_sent++;
  endtask

  // Holds the sender off until every queued record has come out.
  task automatic wait_for_records();
    @(negedge clk);
    archive_valid <= 1'b0;
    while (pending_recs.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic send_header();
    for (int i = 0; i < HDR_BYTES; i++) send_byte(hdr_buf[i]);
    headers_sent++;
  endtask

  // Sends the entry's data blocks, as many as the model still expects, up to max_bytes.
  task automatic send_data(input int max_bytes);
    int n;
    n = 0;
    while (model_ph == tarhp_pkg::PH_SKIP && n < max_bytes) begin
      send_byte(8'($urandom_range(0, 255)));
      n++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Header building.
  // ---------------------------------------------------------------------------
  function automatic void start_header(input int zero_pct);
    for (int i = 0; i < HDR_BYTES; i++)
      hdr_buf[i] = ($urandom_range(0, 99) < zero_pct) ? 8'h00 : 8'($urandom_range(0, 255));
  endfunction

  // Writes a field: nsp spaces, then ndig octal digits of val, then fill.
  function automatic void put_octal(input int at, input int flen, input int nsp,
                                    input int ndig, input logic [63:0] val,
                                    input logic [7:0] fill);
    logic [63:0] sh;
    for (int i = 0; i < flen; i++) begin
      if (i < nsp) begin
        hdr_buf[at + i] = ASCII_SPACE;
      end else if (i < nsp + ndig) begin
        sh              = val >> (3 * (nsp + ndig - 1 - i));
        hdr_buf[at + i] = {5'b00110, sh[2:0]};
      end else begin
        hdr_buf[at + i] = fill;
      end
    end
  endfunction

  function automatic logic [63:0] header_sum();
    logic [63:0] s;
    s = 64'd256;
    for (int i = 0; i < HDR_BYTES; i++)
      if (i < CSUM_AT || i >= CSUM_AT + CSUM_LEN) s = s + hdr_buf[i];
    return s;
  endfunction

  function automatic void seal_checksum(input int nsp, input int ndig,
                                        input logic [7:0] fill);
    put_octal(CSUM_AT, CSUM_LEN, nsp, ndig, header_sum(), fill);
  endfunction

  // Any byte that neither continues nor skips ahead in an octal field.
  function automatic logic [7:0] non_octal_byte();
    logic [7:0] c;
    c = 8'($urandom_range(0, 255));
    if (c >= ASCII_ZERO && c <= ASCII_SEVEN) c = c ^ 8'h40;
    if (c == ASCII_SPACE) c = 8'h60;
    return c;
  endfunction

  // Mostly short entries, some exact block multiples, a few larger ones.
  function automatic logic [63:0] pick_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return 64'd0;
    if (r < 25) return 64'(512 * $urandom_range(1, 4));
    if (r < 70) return 64'($urandom_range(1, 1024));
    if (r < 90) return 64'($urandom_range(1025, 3000));
    return 64'($urandom_range(3001, 6000));
  endfunction

  // A well-formed header with random content and one of the usual spellings
  // of the size and checksum fields.
  task automatic build_good_header();
    logic [63:0] len;
    start_header($urandom_range(0, 90));
    hdr_buf[TYPE_AT] = $urandom_range(0, 1) ? 8'h30 : 8'($urandom_range(0, 255));
    len = pick_length();
    case ($urandom_range(0, 3))
      0:       put_octal(SIZE_AT, SIZE_LEN, 0, 11, len, ASCII_NUL);
      1:       put_octal(SIZE_AT, SIZE_LEN, $urandom_range(1, 3), 8, len, ASCII_SPACE);
      2:       put_octal(SIZE_AT, SIZE_LEN, 0, 12, len, ASCII_NUL);
      default: put_octal(SIZE_AT, SIZE_LEN, 0, 11, len, non_octal_byte());
    endcase
    case ($urandom_range(0, 4))
      0: begin
        seal_checksum(0, 6, ASCII_NUL);
        hdr_buf[CSUM_AT + 7] = ASCII_SPACE;
      end
      1:       seal_checksum(0, 7, ASCII_NUL);
      2:       seal_checksum(0, 8, ASCII_NUL);
      3:       seal_checksum(1, 6, ASCII_SPACE);
      default: seal_checksum(2, 6, non_octal_byte());
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // Directed headers: field extremes, terminators, spacing and checksum faults.
  task automatic test_field_formats();
    // Plain entry of one byte, written the way common archivers write it.
    start_header(80);
    hdr_buf[TYPE_AT] = 8'h30;
    put_octal(SIZE_AT, SIZE_LEN, 0, 11, 64'd1, ASCII_NUL);
    seal_checksum(0, 6, ASCII_NUL);
    hdr_buf[CSUM_AT + 7] = ASCII_SPACE;
    send_header();
    send_data(32'h7FFF_FFFF);

    // All-zero header with zero length: the next byte starts a new header.
    start_header(100);
    put_octal(SIZE_AT, SIZE_LEN, 0, 11, 64'd0, ASCII_NUL);
    seal_checksum(0, 7, ASCII_NUL);
    send_header();

    // Every byte 0xFF gives the largest possible header sum; the checksum
    // field is full of digits with no terminator.
    for (int i = 0; i < HDR_BYTES; i++) hdr_buf[i] = 8'hFF;
    put_octal(SIZE_AT, SIZE_LEN, 0, 11, 64'd512, ASCII_NUL);
    seal_checksum(0, 8, ASCII_NUL);
    send_header();
    send_data(32'h7FFF_FFFF);

    // Size field of twelve digits with no terminator.
    start_header(0);
    put_octal(SIZE_AT, SIZE_LEN, 0, 12, 64'd513, ASCII_NUL);
    seal_checksum(2, 6, ASCII_SPACE);
    send_header();
    send_data(32'h7FFF_FFFF);

    // Leading spaces in both fields.
    start_header(50);
    put_octal(SIZE_AT, SIZE_LEN, 5, 4, 64'd1023, ASCII_SPACE);
    seal_checksum(1, 7, ASCII_NUL);
    send_header();
    send_data(32'h7FFF_FFFF);

    // Size field of spaces only reads as zero.
    start_header(50);
    put_octal(SIZE_AT, SIZE_LEN, SIZE_LEN, 0, 64'd0, ASCII_SPACE);
    seal_checksum(0, 6, ASCII_NUL);
    send_header();

    // A character just below '0' ahead of the digits stops the scan at once.
    start_header(50);
    put_octal(SIZE_AT, SIZE_LEN, 1, 10, 64'd777, ASCII_NUL);
    hdr_buf[SIZE_AT] = ASCII_ZERO - 8'd1;
    seal_checksum(0, 6, ASCII_NUL);
    send_header();

    // Same with a character just above '7'.
    start_header(50);
    put_octal(SIZE_AT, SIZE_LEN, 0, 0, 64'd0, ASCII_SEVEN + 8'd1);
    seal_checksum(0, 6, ASCII_NUL);
    send_header();

    // Digits followed by '9', which ends the field.
    start_header(50);
    put_octal(SIZE_AT, SIZE_LEN, 0, 4, 64'd2047, ASCII_SEVEN + 8'd2);
    seal_checksum(0, 6, ASCII_NUL);
    send_header();
    send_data(32'h7FFF_FFFF);

    // Stored checksum past its 21-bit range saturates and never matches.
    start_header(50);
    put_octal(SIZE_AT, SIZE_LEN, 0, 11, 64'd0, ASCII_NUL);
    put_octal(CSUM_AT, CSUM_LEN, 0, 8, 64'o77777777, ASCII_NUL);
    send_header();

    // Stored checksum exactly at the top of its range, without saturation.
    start_header(50);
    put_octal(SIZE_AT, SIZE_LEN, 0, 11, 64'd0, ASCII_NUL);
    put_octal(CSUM_AT, CSUM_LEN, 0, 7, 64'o7777777, ASCII_NUL);
    send_header();

    // Checksum off by one.
    start_header(50);
    put_octal(SIZE_AT, SIZE_LEN, 0, 11, 64'd100, ASCII_NUL);
    put_octal(CSUM_AT, CSUM_LEN, 0, 6, header_sum() + 1, ASCII_NUL);
    send_header();
    send_data(32'h7FFF_FFFF);

    // Checksum field of spaces only: the stored value is zero.
    start_header(50);
    put_octal(SIZE_AT, SIZE_LEN, 0, 11, 64'd0, ASCII_NUL);
    put_octal(CSUM_AT, CSUM_LEN, CSUM_LEN, 0, 64'd0, ASCII_SPACE);
    send_header();
  endtask

  // A header cut short, then noise until the model is back at a header start.
  // Size-field positions get no digits and the checksum lead byte is never
  // NUL, so the noise can neither start a long skip nor end the archive.
  task automatic send_broken_header();
    int         cut;
    logic [7:0] c;
    build_good_header();
    cut = $urandom_range(1, HDR_BYTES - 1);
    for (int i = 0; i < cut; i++) send_byte(hdr_buf[i]);
    do begin
      c = 8'($urandom_range(0, 255));
      if (model_ph == tarhp_pkg::PH_HEADER) begin
        if (model_hidx >= SIZE_AT && model_hidx < SIZE_AT + SIZE_LEN) c = non_octal_byte();
        if (model_hidx == CSUM_AT) c = 8'($urandom_range(1, 255));
      end
      send_byte(c);
    end while (!(model_ph == tarhp_pkg::PH_HEADER && model_hidx == 0));
    headers_sent++;
  endtask

  // Mostly well-formed entries, with corrupted checksums, pure noise headers
  // and broken headers mixed in.
  task automatic test_random_stream();
    int kind;
    for (int h = 0; h < 50; h++) begin
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
        build_good_header();
        send_header();
      end else if (kind < 80) begin
        build_good_header();
        if ($urandom_range(0, 1))
          hdr_buf[$urandom_range(0, SIZE_AT - 1)] ^= 8'($urandom_range(1, 255));
        else
          hdr_buf[$urandom_range(TYPE_AT + 1, HDR_BYTES - 1)] ^= 8'($urandom_range(1, 255));
        send_header();
      end else if (kind < 90) begin
        // Noise: a non-octal byte inside the size field keeps the length short.
        start_header(0);
        hdr_buf[SIZE_AT + 4] = non_octal_byte();
        hdr_buf[CSUM_AT]     = 8'($urandom_range(1, 255));
        send_header();
      end else begin
        send_broken_header();
      end
      send_data(32'h7FFF_FFFF);
      if (h % 12 == 11) wait_for_records();
    end
  endtask

  // End of archive: a NUL checksum lead byte; everything after is ignored.
  task automatic test_end_marker();
    start_header(30);
    hdr_buf[CSUM_AT] = ASCII_NUL;
    send_header();
    for (int i = 0; i < 600; i++) send_byte(8'($urandom_range(0, 255)));
  endtask

  // A size field at the top of the 33-bit range or beyond it pins the length
  // at 2^33-1. The resulting skip spans 2^33 bytes, so the run ends inside
  // that data.
  task automatic test_size_saturation();
    start_header(50);
    case ($urandom_range(0, 2))
      0:       put_octal(SIZE_AT, SIZE_LEN, 0, 12, 64'o777777777777, ASCII_NUL);
      1:       put_octal(SIZE_AT, SIZE_LEN, 0, 12, 64'o100000000000, ASCII_NUL);
      default: put_octal(SIZE_AT, SIZE_LEN, 0, 11, 64'o77777777777, ASCII_NUL);
    endcase
    seal_checksum(0, 6, ASCII_NUL);
    send_header();
    send_data(1500);
  endtask

  initial begin
    model_reset();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_field_formats();
    wait_for_records();
    test_random_stream();

    // Both an end marker and a saturated length leave the parser stuck for
    // the rest of the run (reset is applied only once), so the seed picks
    // which of the two closes the archive. The 40-bit offset never wraps
    // within a run of this length.
    finale_kind = $urandom_range(0, 1);
    if (finale_kind == 0) test_end_marker();
    else test_size_saturation();

    wait_for_records();
    repeat (32) @(posedge clk);

    $display("Streamed %0d archive bytes in %0d headers; %0d records checked, %0d flagged bad.",
             bytes_sent, headers_sent, records_seen, bad_seen);
    $display("Archive closed by %s.",
             (finale_kind == 0) ? "the end-of-archive marker" : "a saturated size field");
    if (mismatches == 0) begin
      $display("** tar_header_stream_parser_unit: PASSED **");
    end else begin
      $display("** tar_header_stream_parser_unit: FAILED **");
    end
    $finish;
  end

endmodule
